### rtl/rpks_pkg.sv
// Package for the RSSI proximity kill switch.
// Holds the shared widths, reset values, codes and the request and response
// types of the averaging unit. Depends on nothing.
`default_nettype none

package rpks_pkg;

  localparam int WINDOW_LEN_DEF   = 10;
  localparam int KILL_REPEATS_DEF = 3;

  localparam int RSSI_W    = 8;
  localparam int DEBOUNCE_W = 10;
  localparam int TIMEOUT_W = 14;
  localparam int AGE_W     = 16;
  localparam int CFG_W     = 14;
  localparam int CFG_IDX_W = 2;
  localparam int LED_W     = 2;

  localparam logic signed [RSSI_W-1:0] CUTOFF_RST  = -8'sd25;
  localparam logic signed [RSSI_W-1:0] FLOOR_RST   = -8'sd80;
  localparam logic signed [RSSI_W-1:0] AVERAGE_RST = -8'sd128;
  localparam logic [DEBOUNCE_W-1:0]    DEBOUNCE_RST = 10'd50;
  localparam logic [TIMEOUT_W-1:0]     TIMEOUT_RST  = 14'd500;
  localparam logic [AGE_W-1:0]         AGE_MAX      = 16'hFFFF;

  localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOOR    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 2'd3;

  localparam logic OP_TICK   = 1'b0;
  localparam logic OP_PACKET = 1'b1;

  localparam logic [LED_W-1:0] LED_OFF    = 2'd0;
  localparam logic [LED_W-1:0] LED_LINKED = 2'd1;
  localparam logic [LED_W-1:0] LED_RED    = 2'd2;
  localparam logic [LED_W-1:0] LED_YELLOW = 2'd3;

  typedef struct packed {
    logic              start;
    logic              clear;
    logic [RSSI_W-1:0] sample;
  } avg_req_t;

  typedef struct packed {
    logic              done;
    logic [RSSI_W-1:0] average;
  } avg_rsp_t;

endpackage

`default_nettype wire

### rtl/rpks_in_if.sv
// Input channel of the kill switch: one tick or one received packet per beat.
// Depends on rpks_pkg for the field widths.
`default_nettype none

interface rpks_in_if;
  logic                                valid;
  logic                                ready;
  logic                                operation;
  logic                                button_level;
  logic signed [rpks_pkg::RSSI_W-1:0]  rssi;

  modport source (output valid, output operation, output button_level, output rssi,
                  input ready);
  modport sink (input valid, input operation, input button_level, input rssi,
                output ready);
endinterface

`default_nettype wire

### rtl/rpks_out_if.sv
// Result channel of the kill switch: one status or kill result per beat.
// Depends on rpks_pkg for the field widths.
`default_nettype none

interface rpks_out_if;
  logic                               valid;
  logic                               ready;
  logic [rpks_pkg::LED_W-1:0]         led_state;
  logic                               kill_send;
  logic                               armed;
  logic                               connected;
  logic signed [rpks_pkg::RSSI_W-1:0] average_rssi;
  logic                               last;

  modport source (output valid, output led_state, output kill_send, output armed,
                  output connected, output average_rssi, output last, input ready);
  modport sink (input valid, input led_state, input kill_send, input armed,
                input connected, input average_rssi, input last, output ready);
endinterface

`default_nettype wire

### rtl/rpks_avg.sv
// Averaging unit: RSSI ring buffer, then a sequential sum and restoring division
// that share one adder/subtractor. Depends on rpks_pkg.
`default_nettype none

module rpks_avg #(
  parameter int WINDOW_LEN = rpks_pkg::WINDOW_LEN_DEF
) (
  input  wire                clk,
  input  wire                rst,
  input  rpks_pkg::avg_req_t req,
  output rpks_pkg::avg_rsp_t rsp
);

  localparam int IW = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int CW = $clog2(WINDOW_LEN + 1);
  localparam int MW = $clog2(WINDOW_LEN * 128 + 1);
  localparam int SW = MW + 1;
  localparam int AW = MW + 2;
  localparam int STW = $clog2(MW);
  localparam int RW = rpks_pkg::RSSI_W;

  typedef enum logic [4:0] {
    A_IDLE = 5'b00001,
    A_SUM  = 5'b00010,
    A_ABS  = 5'b00100,
    A_DIV  = 5'b01000,
    A_SIGN = 5'b10000
  } avg_state_t;

  avg_state_t state;

  logic [RW-1:0] ram [WINDOW_LEN];
  logic [RW-1:0] rd;
  logic          rd_ok;
  logic [IW-1:0] slot;
  logic          full;
  logic [CW-1:0] count;
  logic [CW-1:0] idx;
  logic [SW-1:0] acc;
  logic [MW-1:0] quo;
  logic [CW-1:0] rem;
  logic [STW-1:0] step;
  logic          neg;
  logic          done;
  logic [RW-1:0] average;

  logic          wrap;
  logic          more;
  logic [CW:0]   rem_sh;
  logic [AW-1:0] alu_a;
  logic [AW-1:0] alu_b;
  logic          alu_sub;
  logic [AW-1:0] alu_y;

  assign wrap   = (slot == IW'(WINDOW_LEN - 1));
  assign more   = (idx < count);
  assign rem_sh = {rem, quo[MW-1]};

  // The shared adder/subtractor of the unit; the state picks its operands.
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state)
      A_SUM: begin
        alu_a = {{(AW-SW){acc[SW-1]}}, acc};
        alu_b = {{(AW-RW){rd[RW-1]}}, rd};
      end
      A_ABS: begin
        alu_b   = {{(AW-SW){acc[SW-1]}}, acc};
        alu_sub = 1'b1;
      end
      A_DIV: begin
        alu_a   = {{(AW-CW-1){1'b0}}, rem_sh};
        alu_b   = {{(AW-CW){1'b0}}, count};
        alu_sub = 1'b1;
      end
      A_SIGN: begin
        alu_b   = {{(AW-MW){1'b0}}, quo};
        alu_sub = 1'b1;
      end
      default: begin
        alu_a = '0;
      end
    endcase
    alu_y = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
  end

  always_ff @(posedge clk) begin
    rd <= ram[idx[IW-1:0]];
    if (req.start) begin
      ram[slot] <= req.sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= A_IDLE;
      slot  <= '0;
      full  <= 1'b0;
      done  <= 1'b0;
      rd_ok <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        A_IDLE: begin
          if (req.clear) begin
            slot <= '0;
            full <= 1'b0;
          end else if (req.start) begin
            slot  <= wrap ? '0 : slot + 1'b1;
            full  <= full | wrap;
            count <= (full || wrap) ? CW'(WINDOW_LEN) : CW'(slot) + 1'b1;
            idx   <= '0;
            rd_ok <= 1'b0;
            acc   <= '0;
            state <= A_SUM;
          end
        end
        A_SUM: begin
          if (more) begin
            idx <= idx + 1'b1;
          end
          rd_ok <= more;
          if (rd_ok) begin
            acc <= alu_y[SW-1:0];
          end
          if (!more && !rd_ok) begin
            state <= A_ABS;
          end
        end
        A_ABS: begin
          neg   <= acc[SW-1];
          quo   <= acc[SW-1] ? alu_y[MW-1:0] : acc[MW-1:0];
          rem   <= '0;
          step  <= '0;
          state <= A_DIV;
        end
        A_DIV: begin
          if (!alu_y[AW-1]) begin
            rem <= alu_y[CW-1:0];
            quo <= {quo[MW-2:0], 1'b1};
          end else begin
            rem <= rem_sh[CW-1:0];
            quo <= {quo[MW-2:0], 1'b0};
          end
          step <= step + 1'b1;
          if (step == STW'(MW - 1)) begin
            state <= A_SIGN;
          end
        end
        A_SIGN: begin
          average <= neg ? alu_y[RW-1:0] : quo[RW-1:0];
          done    <= 1'b1;
          state   <= A_IDLE;
        end
        default: begin
          state <= A_IDLE;
        end
      endcase
    end
  end

  assign rsp.done    = done;
  assign rsp.average = average;

endmodule

`default_nettype wire

### rtl/rssi_proximity_kill_switch.sv
// Top level of the RSSI proximity kill switch: button debounce, link timer,
// arming and kill control, result register. Depends on rpks_pkg, the two
// channel interfaces and rpks_avg.
`default_nettype none

// A tick, an ignored packet and a packet below the floor each give a single
// status result, registered at the edge that takes the beat. A packet that
// enters the window goes through the averaging unit, which adds the filled
// entries one per cycle from its window memory and then divides one quotient
// bit per cycle on the same adder. A kill then gives KILL_REPEATS results,
// one per cycle while they are taken. The input is not ready while a packet
// is being averaged or kill results go out.
module rssi_proximity_kill_switch #(
  parameter int WINDOW_LEN   = rpks_pkg::WINDOW_LEN_DEF,
  parameter int KILL_REPEATS = rpks_pkg::KILL_REPEATS_DEF
) (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             cfg_we,
  input  wire [rpks_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire [rpks_pkg::CFG_W-1:0]       cfg_data,
  rpks_in_if.sink                         item,
  rpks_out_if.source                      result
);

  localparam int KW = $clog2(KILL_REPEATS + 1);
  localparam int RW = rpks_pkg::RSSI_W;
  localparam int GW = rpks_pkg::AGE_W;

  typedef enum logic [2:0] {
    T_IDLE = 3'b001,
    T_AVG  = 3'b010,
    T_EMIT = 3'b100
  } top_state_t;

  top_state_t state;

  logic signed [RW-1:0]                  cutoff;
  logic signed [RW-1:0]                  floor_lvl;
  logic [rpks_pkg::DEBOUNCE_W-1:0]       debounce;
  logic [rpks_pkg::TIMEOUT_W-1:0]        timeout;

  logic                 armed;
  logic                 killed;
  logic                 raw_prev;
  logic                 stable;
  logic [GW-1:0]        steady_age;
  logic [GW-1:0]        link_age;
  logic signed [RW-1:0] held_average;
  logic [KW-1:0]        kcnt;

  logic                          res_valid;
  logic [rpks_pkg::LED_W-1:0]    res_led;
  logic                          res_kill;
  logic                          res_armed;
  logic                          res_conn;
  logic [RW-1:0]                 res_avg;
  logic                          res_last;

  logic                 accept;
  logic                 out_free;
  logic                 is_tick;
  logic                 live;
  logic                 below_floor;
  logic [GW-1:0]        steady_next;
  logic [GW-1:0]        link_tick;
  logic                 press_ok;
  logic                 toggle;
  logic                 armed_next;
  logic                 killed_next;
  logic [GW-1:0]        link_next;
  logic                 conn_next;
  logic                 conn_now;
  logic signed [RW-1:0] avg_new;
  logic                 kill_hit;
  logic                 res_load;

  rpks_pkg::avg_req_t avg_req;
  rpks_pkg::avg_rsp_t avg_rsp;

  function automatic logic [rpks_pkg::LED_W-1:0] led_code(input logic k, input logic a,
                                                          input logic c);
    logic [rpks_pkg::LED_W-1:0] code;
    if (k) begin
      code = rpks_pkg::LED_YELLOW;
    end else if (!a) begin
      code = rpks_pkg::LED_OFF;
    end else if (c) begin
      code = rpks_pkg::LED_LINKED;
    end else begin
      code = rpks_pkg::LED_RED;
    end
    return code;
  endfunction

  assign out_free   = !res_valid || result.ready;
  assign item.ready = (state == T_IDLE) && out_free;
  assign accept     = item.valid && item.ready;

  always_comb begin
    is_tick     = (item.operation == rpks_pkg::OP_TICK);
    live        = armed && !killed;
    below_floor = (item.rssi < floor_lvl);

    if (item.button_level != raw_prev) begin
      steady_next = '0;
    end else if (steady_age == rpks_pkg::AGE_MAX) begin
      steady_next = steady_age;
    end else begin
      steady_next = steady_age + 1'b1;
    end
    press_ok = (steady_next > GW'(debounce)) && (item.button_level != stable);
    toggle   = press_ok && !item.button_level;
    link_tick = (link_age == rpks_pkg::AGE_MAX) ? link_age : link_age + 1'b1;

    if (is_tick) begin
      armed_next  = armed ^ toggle;
      killed_next = killed && !toggle;
      link_next   = link_tick;
    end else begin
      armed_next  = armed;
      killed_next = killed;
      link_next   = live ? '0 : link_age;
    end
    conn_next = (link_next < GW'(timeout));
    conn_now  = (link_age < GW'(timeout));

    avg_new  = $signed(avg_rsp.average);
    kill_hit = (avg_new > cutoff);

    avg_req.start  = accept && !is_tick && live && !below_floor;
    avg_req.clear  = accept && is_tick && toggle;
    avg_req.sample = item.rssi;

    case (state)
      T_IDLE:  res_load = accept && !avg_req.start;
      T_AVG:   res_load = avg_rsp.done && !kill_hit;
      T_EMIT:  res_load = out_free;
      default: res_load = 1'b0;
    endcase
  end

  rpks_avg #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_avg (
    .clk (clk),
    .rst (rst),
    .req (avg_req),
    .rsp (avg_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cutoff    <= rpks_pkg::CUTOFF_RST;
      floor_lvl <= rpks_pkg::FLOOR_RST;
      debounce  <= rpks_pkg::DEBOUNCE_RST;
      timeout   <= rpks_pkg::TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        rpks_pkg::CFG_CUTOFF:   cutoff    <= cfg_data[RW-1:0];
        rpks_pkg::CFG_FLOOR:    floor_lvl <= cfg_data[RW-1:0];
        rpks_pkg::CFG_DEBOUNCE: debounce  <= cfg_data[rpks_pkg::DEBOUNCE_W-1:0];
        rpks_pkg::CFG_TIMEOUT:  timeout   <= cfg_data[rpks_pkg::TIMEOUT_W-1:0];
        default:                cutoff    <= cutoff;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= T_IDLE;
      armed        <= 1'b0;
      killed       <= 1'b0;
      raw_prev     <= 1'b1;
      stable       <= 1'b1;
      steady_age   <= '0;
      link_age     <= rpks_pkg::AGE_MAX;
      held_average <= rpks_pkg::AVERAGE_RST;
      kcnt         <= '0;
      res_valid    <= 1'b0;
    end else begin
      res_valid <= res_load || (res_valid && !result.ready);
      case (state)
        T_IDLE: begin
          if (accept) begin
            armed    <= armed_next;
            killed   <= killed_next;
            link_age <= link_next;
            if (is_tick) begin
              steady_age <= steady_next;
              raw_prev   <= item.button_level;
              if (press_ok) begin
                stable <= item.button_level;
              end
            end
            if (avg_req.start) begin
              state <= T_AVG;
            end else begin
              res_led   <= led_code(killed_next, armed_next, conn_next);
              res_kill  <= 1'b0;
              res_armed <= armed_next;
              res_conn  <= conn_next;
              res_avg   <= held_average;
              res_last  <= 1'b1;
            end
          end
        end
        T_AVG: begin
          if (avg_rsp.done) begin
            held_average <= avg_new;
            if (kill_hit) begin
              killed <= 1'b1;
              kcnt   <= '0;
              state  <= T_EMIT;
            end else begin
              res_led   <= led_code(1'b0, armed, conn_now);
              res_kill  <= 1'b0;
              res_armed <= armed;
              res_conn  <= conn_now;
              res_avg   <= avg_new;
              res_last  <= 1'b1;
              state     <= T_IDLE;
            end
          end
        end
        T_EMIT: begin
          if (out_free) begin
            res_led   <= led_code(killed, armed, conn_now);
            res_kill  <= 1'b1;
            res_armed <= armed;
            res_conn  <= conn_now;
            res_avg   <= held_average;
            res_last  <= (kcnt == KW'(KILL_REPEATS - 1));
            kcnt      <= kcnt + 1'b1;
            if (kcnt == KW'(KILL_REPEATS - 1)) begin
              state <= T_IDLE;
            end
          end
        end
        default: begin
          state <= T_IDLE;
        end
      endcase
    end
  end

  assign result.valid        = res_valid;
  assign result.led_state    = res_led;
  assign result.kill_send    = res_kill;
  assign result.armed        = res_armed;
  assign result.connected    = res_conn;
  assign result.average_rssi = res_avg;
  assign result.last         = res_last;

endmodule

`default_nettype wire

### tb/sv/tb.sv
// Self-checking testbench for rssi_proximity_kill_switch: sends tick and packet beats,
// predicts every status and kill beat from its own copy of the switch state, and checks
// them in order. Depends on rpks_pkg, rpks_in_if, rpks_out_if and the top-level RTL.
module tb;

  localparam int RSSI_W      = rpks_pkg::RSSI_W;
  localparam int LED_W       = rpks_pkg::LED_W;
  localparam int CFG_IDX_W   = rpks_pkg::CFG_IDX_W;
  localparam int CFG_W       = rpks_pkg::CFG_W;
  localparam int DEBOUNCE_W  = rpks_pkg::DEBOUNCE_W;
  localparam int TIMEOUT_W   = rpks_pkg::TIMEOUT_W;
  localparam int AGE_W       = rpks_pkg::AGE_W;
  localparam int WINDOW      = rpks_pkg::WINDOW_LEN_DEF;
  localparam int KILLS       = rpks_pkg::KILL_REPEATS_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE      = 40;
  localparam int LONG_HOLD   = 300;
  localparam logic BTN_PRESSED  = 1'b0;
  localparam logic BTN_RELEASED = 1'b1;

  typedef struct {
    logic                     op;
    logic                     btn;
    logic signed [RSSI_W-1:0] rssi;
  } beat_t;

  typedef struct packed {
    logic [LED_W-1:0]         led;
    logic                     kill;
    logic                     armed;
    logic                     conn;
    logic signed [RSSI_W-1:0] avg;
    logic                     last;
  } status_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  rpks_in_if  item_ch ();
  rpks_out_if result_ch ();

  rssi_proximity_kill_switch dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item_ch),
    .result    (result_ch)
  );

  beat_t   beats_to_send [$];
  status_t status_due [$];
  int      mismatches;
  int      cycles;
  bit      beat_taken;
  bit      quiet;
  int      gap_left;
  int      pause_left;
  int      hold_left;
  int      holds_asked;
  int      holds_done;

  logic signed [RSSI_W-1:0] cut_lim;
  logic signed [RSSI_W-1:0] floor_lim;
  logic [DEBOUNCE_W-1:0]    debounce_lim;
  logic [TIMEOUT_W-1:0]     timeout_lim;

  logic                     is_armed;
  logic                     is_killed;
  logic signed [RSSI_W-1:0] window_mem [WINDOW];
  int                       fill_slot;
  logic                     fill_wrapped;
  logic                     btn_prev;
  logic                     btn_stable;
  logic [AGE_W-1:0]         btn_age;
  logic [AGE_W-1:0]         link_age;
  logic signed [RSSI_W-1:0] mean_rssi;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("rssi_proximity_kill_switch test failed");
    $finish;
  end

  function automatic string show(status_t s);
    return $sformatf("led=%0d kill=%0d armed=%0d conn=%0d avg=%0d last=%0d",
                     s.led, s.kill, s.armed, s.conn, $signed(s.avg), s.last);
  endfunction

  function automatic void queue_status(logic kill, logic last);
    status_t s;
    logic    conn;
    conn = int'(link_age) < int'(timeout_lim);
    if (is_killed) s.led = rpks_pkg::LED_YELLOW;
    else if (!is_armed) s.led = rpks_pkg::LED_OFF;
    else if (conn) s.led = rpks_pkg::LED_LINKED;
    else s.led = rpks_pkg::LED_RED;
    s.kill  = kill;
    s.armed = is_armed;
    s.conn  = conn;
    s.avg   = mean_rssi;
    s.last  = last;
    status_due.push_back(s);
  endfunction

  function automatic void predict_status(beat_t b);
    int total;
    int count;
    int i;
    if (b.op == rpks_pkg::OP_TICK) begin
      if (b.btn != btn_prev) btn_age = '0;
      else if (btn_age != rpks_pkg::AGE_MAX) btn_age++;
      if (btn_age > debounce_lim && b.btn != btn_stable) begin
        btn_stable = b.btn;
        if (btn_stable == BTN_PRESSED) begin
          is_armed     = !is_armed;
          fill_slot    = 0;
          fill_wrapped = 1'b0;
          is_killed    = 1'b0;
        end
      end
      btn_prev = b.btn;
      if (link_age != rpks_pkg::AGE_MAX) link_age++;
      queue_status(1'b0, 1'b1);
    end else if (!is_armed || is_killed) begin
      queue_status(1'b0, 1'b1);
    end else begin
      link_age = '0;
      if (b.rssi < floor_lim) begin
        queue_status(1'b0, 1'b1);
      end else begin
        window_mem[fill_slot] = b.rssi;
        fill_slot++;
        if (fill_slot == WINDOW) begin
          fill_slot    = 0;
          fill_wrapped = 1'b1;
        end
        count = fill_wrapped ? WINDOW : fill_slot;
        total = 0;
        for (i = 0; i < count; i++) total += int'(window_mem[i]);
        mean_rssi = RSSI_W'(total / count);
        if (mean_rssi > cut_lim) begin
          is_killed = 1'b1;
          for (i = 0; i < KILLS; i++) queue_status(1'b1, i == KILLS - 1);
        end else begin
          queue_status(1'b0, 1'b1);
        end
      end
    end
  endfunction

  // Driver: holds a beat until it is taken, with short random gaps between beats unless quiet is set.
  always @(negedge clk) begin
    bit offer;
    offer = 1'b0;
    if (!rst) begin
      if (item_ch.valid && !beat_taken) offer = 1'b1;
      else if (gap_left > 0) gap_left--;
      else if (beats_to_send.size() > 0) begin
        if (!quiet && $urandom_range(0, 5) == 0) gap_left = $urandom_range(0, 2);
        else offer = 1'b1;
      end
    end
    beat_taken = 1'b0;
    item_ch.valid <= offer;
    if (offer) begin
      item_ch.operation    <= beats_to_send[0].op;
      item_ch.button_level <= beats_to_send[0].btn;
      item_ch.rssi         <= beats_to_send[0].rssi;
    end
  end

  always @(negedge clk) begin
    logic take;
    take = 1'b0;
    if (!rst) begin
      if (hold_left == 0 && holds_done != holds_asked) begin
        hold_left = LONG_HOLD;
        holds_done++;
      end
      if (hold_left > 0) hold_left--;
      else if (pause_left > 0) pause_left--;
      else if (!quiet && $urandom_range(0, 5) == 0) pause_left = $urandom_range(0, 2);
      else take = 1'b1;
    end
    result_ch.ready <= take;
  end

  // Monitor: checks each result beat against the oldest prediction, then predicts
  // the beats caused by an input beat taken at this edge.
  always @(posedge clk) begin
    status_t got;
    status_t want;
    beat_t   b;
    if (!rst) begin
      if (result_ch.valid && result_ch.ready) begin
        got.led   = result_ch.led_state;
        got.kill  = result_ch.kill_send;
        got.armed = result_ch.armed;
        got.conn  = result_ch.connected;
        got.avg   = result_ch.average_rssi;
        got.last  = result_ch.last;
        if (status_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat: %s", show(got));
        end else begin
          want = status_due.pop_front();
          if (got.led !== want.led || got.kill !== want.kill || got.armed !== want.armed ||
              got.conn !== want.conn || got.avg !== want.avg || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected %s, actual %s", show(want), show(got));
          end
        end
      end
      if (item_ch.valid && item_ch.ready) begin
        b.op   = item_ch.operation;
        b.btn  = item_ch.button_level;
        b.rssi = item_ch.rssi;
        predict_status(b);
        void'(beats_to_send.pop_front());
        beat_taken = 1'b1;
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      rpks_pkg::CFG_CUTOFF:   cut_lim      = data[RSSI_W-1:0];
      rpks_pkg::CFG_FLOOR:    floor_lim    = data[RSSI_W-1:0];
      rpks_pkg::CFG_DEBOUNCE: debounce_lim = data[DEBOUNCE_W-1:0];
      rpks_pkg::CFG_TIMEOUT:  timeout_lim  = data[TIMEOUT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_limits(int cut, int flr, int deb, int tmo);
    write_reg(rpks_pkg::CFG_CUTOFF, CFG_W'(cut));
    write_reg(rpks_pkg::CFG_FLOOR, CFG_W'(flr));
    write_reg(rpks_pkg::CFG_DEBOUNCE, CFG_W'(deb));
    write_reg(rpks_pkg::CFG_TIMEOUT, CFG_W'(tmo));
  endtask

  function automatic void push_tick(logic btn);
    beat_t b;
    b.op   = rpks_pkg::OP_TICK;
    b.btn  = btn;
    b.rssi = RSSI_W'($urandom);
    beats_to_send.push_back(b);
  endfunction

  function automatic void push_packet(logic signed [RSSI_W-1:0] r);
    beat_t b;
    b.op   = rpks_pkg::OP_PACKET;
    b.btn  = 1'($urandom_range(0, 1));
    b.rssi = r;
    beats_to_send.push_back(b);
  endfunction

  // A press long enough to be accepted, then a release long enough to be accepted.
  function automatic void push_press();
    int n;
    n = int'(debounce_lim) + 2;
    repeat (n) push_tick(BTN_PRESSED);
    repeat (n) push_tick(BTN_RELEASED);
  endfunction

  function automatic logic signed [RSSI_W-1:0] pick_rssi();
    int lo;
    lo = int'(floor_lim) - 8;
    if (lo < -128) lo = -128;
    if ($urandom_range(0, 99) < 6) return RSSI_W'($urandom_range(1, 127));
    return RSSI_W'(lo + int'($urandom_range(0, -lo)));
  endfunction

  function automatic void push_mix(int n);
    int pick;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) push_packet(pick_rssi());
      else if (pick < 80) push_tick(BTN_RELEASED);
      else if (pick < 90 || debounce_lim > 8) begin
        push_tick(BTN_PRESSED);
        push_tick(BTN_RELEASED);
      end else begin
        push_press();
        push_press();
      end
    end
  endfunction

  task automatic wait_idle();
    while (beats_to_send.size() != 0 || status_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic run_phase(int cut, int flr, int deb, int tmo, int n, bit long_hold);
    set_limits(cut, flr, deb, tmo);
    if (deb <= 8) begin
      if (is_killed) begin
        push_press();
        push_press();
      end else if (!is_armed) begin
        push_press();
      end
    end
    if (long_hold) holds_asked++;
    push_mix(n);
    wait_idle();
  endtask

  initial begin
    rst                  = 1'b1;
    cfg_we               = 1'b0;
    cfg_index            = '0;
    cfg_data             = '0;
    item_ch.valid        = 1'b0;
    item_ch.operation    = rpks_pkg::OP_TICK;
    item_ch.button_level = BTN_RELEASED;
    item_ch.rssi         = '0;
    result_ch.ready      = 1'b0;
    quiet        = 1'b0;
    mismatches   = 0;
    beat_taken   = 1'b0;
    gap_left     = 0;
    pause_left   = 0;
    hold_left    = 0;
    holds_asked  = 0;
    holds_done   = 0;
    cut_lim      = rpks_pkg::CUTOFF_RST;
    floor_lim    = rpks_pkg::FLOOR_RST;
    debounce_lim = rpks_pkg::DEBOUNCE_RST;
    timeout_lim  = rpks_pkg::TIMEOUT_RST;
    is_armed     = 1'b0;
    is_killed    = 1'b0;
    fill_slot    = 0;
    fill_wrapped = 1'b0;
    btn_prev     = BTN_RELEASED;
    btn_stable   = BTN_RELEASED;
    btn_age      = '0;
    link_age     = rpks_pkg::AGE_MAX;
    mean_rssi    = rpks_pkg::AVERAGE_RST;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Disarmed: packets are ignored and a one-tick glitch is not a press.
    push_tick(BTN_RELEASED);
    push_packet(-10);
    push_tick(BTN_PRESSED);
    push_tick(BTN_RELEASED);
    push_packet(-128);
    wait_idle();

    // Arm, drop a weak packet, lose the link, then average up to a kill.
    set_limits(-25, -80, 1, 3);
    push_press();
    push_packet(-128);
    push_tick(BTN_RELEASED);
    push_packet(-80);
    repeat (4) push_tick(BTN_RELEASED);
    repeat (3) push_packet(0);
    push_packet(-50);
    push_tick(BTN_RELEASED);
    wait_idle();

    run_phase(0, -128, 0, 1, 18, 1'b0);
    run_phase(-128, 0, 2, 10000, 18, 1'b0);
    run_phase(-int'($urandom_range(10, 60)), -int'($urandom_range(60, 100)),
              $urandom_range(0, 4), $urandom_range(1, 40), 18, 1'b1);
    repeat (2)
      run_phase(-int'($urandom_range(10, 60)), -int'($urandom_range(60, 100)),
                $urandom_range(0, 4), $urandom_range(1, 40), 18, 1'b0);
    run_phase(-int'($urandom_range(10, 60)), -128, 1000, 0, 20, 1'b0);
    quiet = 1'b1;
    run_phase(-25, -80, 3, 500, 18, 1'b0);

    if (mismatches == 0) begin
      $display("rssi_proximity_kill_switch test passed");
    end else begin
      $display("rssi_proximity_kill_switch test failed");
    end
    $finish;
  end

endmodule

### sim.f
rtl/rpks_pkg.sv
rtl/rpks_in_if.sv
rtl/rpks_out_if.sv
rtl/rpks_avg.sv
rtl/rssi_proximity_kill_switch.sv
tb/sv/tb.sv
